@@ rtl/yuvskip_pkg.sv @@
// package for the yuv pixel-pair to rgb converter with skip flags
// holds item types, coefficients and widths; no dependencies
`default_nettype none

package yuvskip_pkg;

	localparam int unsigned PIX_W     = 8;
	// signed width of the scaled sums before the shift
	localparam int unsigned SUM_W     = 18;
	localparam int unsigned IN_DATA_W  = 64;
	localparam int unsigned OUT_DATA_W = 56;

	localparam logic signed [SUM_W-1:0] COEF_RV = 18'sd358;
	localparam logic signed [SUM_W-1:0] COEF_GU = 18'sd88;
	localparam logic signed [SUM_W-1:0] COEF_GV = 18'sd182;
	localparam logic signed [SUM_W-1:0] COEF_BU = 18'sd453;
	localparam logic [PIX_W:0]          CHROMA_OFFSET = 9'd128;
	localparam logic [PIX_W-1:0]        PIX_MAX = 8'd255;

	typedef struct packed {
		logic [PIX_W-1:0] luma_even;
		logic [PIX_W-1:0] luma_odd;
		logic [PIX_W-1:0] chroma_u;
		logic [PIX_W-1:0] chroma_v;
		logic [PIX_W-1:0] prev_luma_even;
		logic [PIX_W-1:0] prev_luma_odd;
		logic [PIX_W-1:0] prev_chroma_u;
		logic [PIX_W-1:0] prev_chroma_v;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		rgb_t pix_even;
		logic write_even;
		rgb_t pix_odd;
		logic write_odd;
	} out_item_t;

endpackage

`default_nettype wire

@@ rtl/yuvskip_pixel.sv @@
// color conversion of one pixel: fixed-point bt601 matrix, floor shift, clip
// depends on yuvskip_pkg
`default_nettype none

module yuvskip_pixel (
	input  wire logic [yuvskip_pkg::PIX_W-1:0]   luma,
	input  wire logic signed [yuvskip_pkg::PIX_W:0] u,
	input  wire logic signed [yuvskip_pkg::PIX_W:0] v,
	output yuvskip_pkg::rgb_t                    rgb
);

	logic signed [yuvskip_pkg::SUM_W-1:0] y_scaled;
	logic signed [yuvskip_pkg::SUM_W-1:0] u_ext;
	logic signed [yuvskip_pkg::SUM_W-1:0] v_ext;
	logic signed [yuvskip_pkg::SUM_W-1:0] r_sum;
	logic signed [yuvskip_pkg::SUM_W-1:0] g_sum;
	logic signed [yuvskip_pkg::SUM_W-1:0] b_sum;

	// floor shift by 8 then clip to 0..255, taken straight from the sum
	function automatic logic [yuvskip_pkg::PIX_W-1:0] clip_shift(
		input logic signed [yuvskip_pkg::SUM_W-1:0] s
	);
		logic [yuvskip_pkg::PIX_W-1:0] res;
		if (s[yuvskip_pkg::SUM_W-1]) begin
			res = '0;
		end else if (|s[yuvskip_pkg::SUM_W-2:16]) begin
			res = yuvskip_pkg::PIX_MAX;
		end else begin
			res = s[15:8];
		end
		return res;
	endfunction

	always_comb begin
		y_scaled = signed'({2'b00, luma, 8'h00});
		u_ext    = yuvskip_pkg::SUM_W'(u);
		v_ext    = yuvskip_pkg::SUM_W'(v);
		r_sum    = y_scaled + yuvskip_pkg::COEF_RV * v_ext;
		g_sum    = y_scaled - yuvskip_pkg::COEF_GU * u_ext - yuvskip_pkg::COEF_GV * v_ext;
		b_sum    = y_scaled + yuvskip_pkg::COEF_BU * u_ext;
		rgb.red   = clip_shift(r_sum);
		rgb.green = clip_shift(g_sum);
		rgb.blue  = clip_shift(b_sum);
	end

endmodule

`default_nettype wire

@@ rtl/yuv_pair_to_rgb_with_skip_unit.sv @@
// Pixel-pair yuv to rgb converter with unchanged-pixel skip flags. Each input
// transfer carries two adjacent luma samples sharing one u/v pair, plus the
// same samples from the previous frame; each output transfer carries the
// clipped bt601 rgb of both pixels and a write flag per pixel that is low only
// when that pixel's luma and the shared chroma all match the previous frame.
// Each pair passes an input register, then a result register, and one pair
// is taken every clock while the output side keeps tready high; the color
// math is a single pass of constant multiplies and adds per pixel between
// the two registers. Input tready follows output tready combinationally
// through the two-entry pipeline, so a stalled result still lets one more
// pair enter. No configuration, no state beyond the pipeline.
// depends on yuvskip_pkg and yuvskip_pixel
`default_nettype none

module yuv_pair_to_rgb_with_skip_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// luma_even, luma_odd, chroma_u, chroma_v, prev_luma_even,
	// prev_luma_odd, prev_chroma_u, prev_chroma_v (8 bits each, low first)
	input  wire logic [63:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// red_even[7:0], green_even[15:8], blue_even[23:16], write_even[24],
	// red_odd[32:25], green_odd[40:33], blue_odd[48:41], write_odd[49],
	// zero fill [55:50]
	output logic [55:0]      m_axis_tdata
);

	yuvskip_pkg::in_item_t  in_item;
	yuvskip_pkg::in_item_t  item_s1;
	yuvskip_pkg::out_item_t res_comb;
	yuvskip_pkg::out_item_t res_s2;
	logic                   valid_s1;
	logic                   valid_s2;
	logic                   load_s1;
	logic                   load_s2;
	logic                   s2_free;
	logic signed [yuvskip_pkg::PIX_W:0] u_c;
	logic signed [yuvskip_pkg::PIX_W:0] v_c;
	logic                   chroma_same;

	// unpack the input transfer, first field in the low byte
	always_comb begin
		in_item.luma_even      = s_axis_tdata[7:0];
		in_item.luma_odd       = s_axis_tdata[15:8];
		in_item.chroma_u       = s_axis_tdata[23:16];
		in_item.chroma_v       = s_axis_tdata[31:24];
		in_item.prev_luma_even = s_axis_tdata[39:32];
		in_item.prev_luma_odd  = s_axis_tdata[47:40];
		in_item.prev_chroma_u  = s_axis_tdata[55:48];
		in_item.prev_chroma_v  = s_axis_tdata[63:56];
	end

	// handshake: the result register frees when empty or taken this cycle,
	// stage one frees when empty or moving on into the result register
	assign s2_free       = !valid_s2 || m_axis_tready;
	assign load_s2       = valid_s1 && s2_free;
	assign s_axis_tready = !valid_s1 || s2_free;
	assign load_s1       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1 <= in_item;
		end
		if (load_s2) begin
			res_s2 <= res_comb;
		end
	end

	// chroma centered around zero
	assign u_c = signed'({1'b0, item_s1.chroma_u} - yuvskip_pkg::CHROMA_OFFSET);
	assign v_c = signed'({1'b0, item_s1.chroma_v} - yuvskip_pkg::CHROMA_OFFSET);

	yuvskip_pixel u_pix_even (
		.luma (item_s1.luma_even),
		.u    (u_c),
		.v    (v_c),
		.rgb  (res_comb.pix_even)
	);

	yuvskip_pixel u_pix_odd (
		.luma (item_s1.luma_odd),
		.u    (u_c),
		.v    (v_c),
		.rgb  (res_comb.pix_odd)
	);

	// skip only when the pixel and its shared chroma are unchanged
	assign chroma_same = (item_s1.chroma_u == item_s1.prev_chroma_u) &&
		(item_s1.chroma_v == item_s1.prev_chroma_v);
	assign res_comb.write_even = !(chroma_same &&
		(item_s1.luma_even == item_s1.prev_luma_even));
	assign res_comb.write_odd = !(chroma_same &&
		(item_s1.luma_odd == item_s1.prev_luma_odd));

	// pack the result transfer, first field in the low bits
	always_comb begin
		m_axis_tdata         = '0;
		m_axis_tdata[7:0]    = res_s2.pix_even.red;
		m_axis_tdata[15:8]   = res_s2.pix_even.green;
		m_axis_tdata[23:16]  = res_s2.pix_even.blue;
		m_axis_tdata[24]     = res_s2.write_even;
		m_axis_tdata[32:25]  = res_s2.pix_odd.red;
		m_axis_tdata[40:33]  = res_s2.pix_odd.green;
		m_axis_tdata[48:41]  = res_s2.pix_odd.blue;
		m_axis_tdata[49]     = res_s2.write_odd;
	end

	// stage one moving on always leaves a valid result behind
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 |=> valid_s2)
		else $error("stage one item lost on its way to the result register");

	// input is only held off while stage one is occupied
	a_ready_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && valid_s2 && !m_axis_tready))
		else $error("input stalled without a full pipeline");

	// an unchanged even pixel must come out with its write flag low
	a_skip_even: assert property (@(posedge clk) disable iff (!arst_n)
		(load_s2 && chroma_same && (item_s1.luma_even == item_s1.prev_luma_even))
		|=> !res_s2.write_even)
		else $error("unchanged even pixel flagged for write");

	// a changed chroma forces both pixels to be written
	a_chroma_write: assert property (@(posedge clk) disable iff (!arst_n)
		(load_s2 && !chroma_same) |=> (res_s2.write_even && res_s2.write_odd))
		else $error("chroma change did not flag both pixels");

endmodule

`default_nettype wire

@@ tb/tb_yuv_pair_to_rgb_with_skip_unit.sv @@
// testbench for yuv_pair_to_rgb_with_skip_unit: a directed list of pixel pairs, then random
// pairs under sender bursts and receiver stalls, every result checked field by field
// depends on yuvskip_pkg and the unit rtl
module tb_yuv_pair_to_rgb_with_skip_unit;

	localparam int RANDOM_PAIRS = 1200;
	localparam int RESET_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_AFTER   = 400;
	localparam int HOLD_CYCLES  = 300;
	localparam int PRINT_CAP    = 40;

	// bt601 fixed point gains, chroma centered on the mid code
	localparam int CHROMA_MID = 128;
	localparam int RV_GAIN    = 358;
	localparam int GU_GAIN    = 88;
	localparam int GV_GAIN    = 182;
	localparam int BU_GAIN    = 453;
	localparam int LEVEL_MAX  = 255;

	typedef struct {
		yuvskip_pkg::in_item_t  pair;
		bit                     known;
		yuvskip_pkg::out_item_t want;
	} pair_case_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               s_axis_tvalid = 1'b0;
	logic                               s_axis_tready;
	logic [yuvskip_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                               m_axis_tvalid;
	logic                               m_axis_tready = 1'b0;
	logic [yuvskip_pkg::OUT_DATA_W-1:0] m_axis_tdata;

	pair_case_t             directed_pairs[$];
	yuvskip_pkg::out_item_t rgb_pending[$];
	int         mismatch_count = 0;
	int         results_seen = 0;
	int         pairs_sent = 0;
	int         cycle_count = 0;

	yuv_pair_to_rgb_with_skip_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic [yuvskip_pkg::PIX_W-1:0] clip_level(int x);
		if (x < 0)
			return '0;
		if (x > LEVEL_MAX)
			return yuvskip_pkg::PIX_W'(LEVEL_MAX);
		return yuvskip_pkg::PIX_W'(x);
	endfunction

	// one pixel, floor shift on the scaled sums, then clip
	function automatic yuvskip_pkg::rgb_t pixel_rgb(int y, int u, int v);
		int                ys;
		yuvskip_pkg::rgb_t px;
		ys = y * 256;
		px.red   = clip_level((ys + RV_GAIN * v) >>> 8);
		px.green = clip_level((ys - GU_GAIN * u - GV_GAIN * v) >>> 8);
		px.blue  = clip_level((ys + BU_GAIN * u) >>> 8);
		return px;
	endfunction

	function automatic yuvskip_pkg::out_item_t convert_pair(yuvskip_pkg::in_item_t p);
		int                     y_even, y_odd, u, v;
		bit                     chroma_same;
		yuvskip_pkg::out_item_t r;
		y_even = p.luma_even;
		y_odd  = p.luma_odd;
		u = p.chroma_u;
		v = p.chroma_v;
		u -= CHROMA_MID;
		v -= CHROMA_MID;
		chroma_same = (p.chroma_u == p.prev_chroma_u) && (p.chroma_v == p.prev_chroma_v);
		r.pix_even   = pixel_rgb(y_even, u, v);
		r.pix_odd    = pixel_rgb(y_odd, u, v);
		r.write_even = !(chroma_same && p.luma_even == p.prev_luma_even);
		r.write_odd  = !(chroma_same && p.luma_odd == p.prev_luma_odd);
		return r;
	endfunction

	// luma_even in the low byte up to prev_chroma_v in the top byte
	function automatic logic [yuvskip_pkg::IN_DATA_W-1:0] pack_pair(yuvskip_pkg::in_item_t p);
		return {p.prev_chroma_v, p.prev_chroma_u, p.prev_luma_odd, p.prev_luma_even,
			p.chroma_v, p.chroma_u, p.luma_odd, p.luma_even};
	endfunction

	function automatic yuvskip_pkg::out_item_t unpack_rgb(
			logic [yuvskip_pkg::OUT_DATA_W-1:0] d);
		yuvskip_pkg::out_item_t r;
		r.pix_even.red   = d[7:0];
		r.pix_even.green = d[15:8];
		r.pix_even.blue  = d[23:16];
		r.write_even     = d[24];
		r.pix_odd.red    = d[32:25];
		r.pix_odd.green  = d[40:33];
		r.pix_odd.blue   = d[48:41];
		r.write_odd      = d[49];
		return r;
	endfunction

	// neutral chroma gives r = g = b = luma
	function automatic yuvskip_pkg::out_item_t grey_result(
			logic [yuvskip_pkg::PIX_W-1:0] y_even, logic w_even,
			logic [yuvskip_pkg::PIX_W-1:0] y_odd, logic w_odd);
		yuvskip_pkg::out_item_t r;
		r.pix_even   = {y_even, y_even, y_even};
		r.write_even = w_even;
		r.pix_odd    = {y_odd, y_odd, y_odd};
		r.write_odd  = w_odd;
		return r;
	endfunction

	function automatic logic [yuvskip_pkg::PIX_W-1:0] extreme_level();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd127;
			3: return 8'd128;
			4: return 8'd254;
			default: return 8'd255;
		endcase
	endfunction

	function automatic yuvskip_pkg::in_item_t random_pair();
		yuvskip_pkg::in_item_t p;
		int                    mode;
		mode = $urandom_range(0, 9);
		p.luma_even      = 8'($urandom);
		p.luma_odd       = 8'($urandom);
		p.chroma_u       = 8'($urandom);
		p.chroma_v       = 8'($urandom);
		p.prev_luma_even = 8'($urandom);
		p.prev_luma_odd  = 8'($urandom);
		p.prev_chroma_u  = 8'($urandom);
		p.prev_chroma_v  = 8'($urandom);
		if (mode >= 8) begin
			// drive the clip limits
			p.luma_even = extreme_level();
			p.luma_odd  = extreme_level();
			p.chroma_u  = extreme_level();
			p.chroma_v  = extreme_level();
		end
		if (mode <= 5) begin
			// static picture area: previous frame matches, now and then one sample moves by a bit
			p.prev_luma_even = p.luma_even;
			p.prev_luma_odd  = p.luma_odd;
			p.prev_chroma_u  = p.chroma_u;
			p.prev_chroma_v  = p.chroma_v;
			case ($urandom_range(0, 6))
				0: p.prev_luma_even ^= 8'(1 << $urandom_range(0, 7));
				1: p.prev_luma_odd  ^= 8'(1 << $urandom_range(0, 7));
				2: p.prev_chroma_u  ^= 8'(1 << $urandom_range(0, 7));
				3: p.prev_chroma_v  ^= 8'(1 << $urandom_range(0, 7));
				default: ;
			endcase
		end
		return p;
	endfunction

	task automatic add_row(input logic [yuvskip_pkg::PIX_W-1:0] le, lo, cu, cv, ple, plo,
			pcu, pcv, input bit known, input yuvskip_pkg::out_item_t want);
		pair_case_t c;
		c.pair  = '{le, lo, cu, cv, ple, plo, pcu, pcv};
		c.known = known;
		c.want  = want;
		directed_pairs.push_back(c);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatch_count < PRINT_CAP)
			$display("mismatch at result %0d: %s got %0d want %0d", results_seen, what, got,
				want);
		mismatch_count++;
	endtask

	task automatic check_field(input string what, input int got, input int want);
		if (got != want)
			report_mismatch(what, got, want);
	endtask

	// sender: directed list first, then random pairs, in bursts with random gaps
	initial begin : drive_pairs
		yuvskip_pkg::in_item_t  pair;
		yuvskip_pkg::out_item_t want;
		bit        known;
		int        burst_left;
		int        gap;
		int        total;
		burst_left = 0;

		//      le   lo   u    v    ple  plo  pu   pv
		// neutral chroma, known grey results and skip flags
		add_row(0,   0,   128, 128, 0,   0,   128, 128, 1, grey_result(0, 0, 0, 0));
		add_row(255, 255, 128, 128, 255, 255, 128, 128, 1, grey_result(255, 0, 255, 0));
		add_row(100, 200, 128, 128, 100, 201, 128, 128, 1, grey_result(100, 0, 200, 1));
		add_row(100, 200, 128, 128, 99,  200, 128, 128, 1, grey_result(100, 1, 200, 0));
		// one or both chroma samples changed: both pixels rewritten
		add_row(50,  60,  128, 128, 50,  60,  129, 128, 1, grey_result(50, 1, 60, 1));
		add_row(50,  60,  128, 128, 50,  60,  128, 127, 1, grey_result(50, 1, 60, 1));
		add_row(0,   255, 128, 128, 255, 0,   0,   0,   1, grey_result(0, 1, 255, 1));
		// chroma extremes, clipping at both ends
		add_row(0,   255, 0,   0,   0,   255, 0,   0,   0, '0);
		add_row(0,   255, 255, 255, 17,  3,   200, 9,   0, '0);
		add_row(0,   255, 0,   255, 0,   255, 0,   255, 0, '0);
		add_row(0,   255, 255, 0,   0,   0,   255, 0,   0, '0);
		add_row(255, 0,   0,   0,   255, 0,   1,   0,   0, '0);
		add_row(255, 0,   255, 255, 255, 0,   255, 255, 0, '0);
		add_row(128, 128, 0,   255, 127, 129, 0,   255, 0, '0);
		// chroma one code off center: floor of small fractional sums
		add_row(10,  10,  128, 129, 10,  10,  128, 129, 0, '0);
		add_row(10,  10,  128, 127, 0,   0,   0,   0,   0, '0);
		add_row(10,  10,  127, 128, 10,  11,  127, 128, 0, '0);
		add_row(10,  10,  129, 128, 11,  10,  129, 128, 0, '0);
		// saturated colors
		add_row(235, 16,  240, 16,  0,   0,   0,   0,   0, '0);
		add_row(16,  235, 16,  240, 16,  235, 16,  240, 0, '0);
		add_row(255, 255, 255, 255, 255, 255, 255, 255, 0, '0);
		add_row(1,   254, 1,   254, 254, 1,   254, 1,   0, '0);

		total = directed_pairs.size() + RANDOM_PAIRS;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int n = 0; n < total; n++) begin
			if (n < directed_pairs.size()) begin
				pair  = directed_pairs[n].pair;
				known = directed_pairs[n].known;
				want  = directed_pairs[n].want;
			end else begin
				pair  = random_pair();
				known = 1'b0;
			end
			if (!known)
				want = convert_pair(pair);

			gap = 0;
			if (burst_left == 0) begin
				gap = $urandom_range(1, 10);
				// mostly short bursts, now and then a long unbroken run
				burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
					: $urandom_range(1, 30);
			end
			burst_left--;
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			s_axis_tvalid <= 1'b1;
			s_axis_tdata  <= pack_pair(pair);
			@(posedge clk);
			while (!s_axis_tready)
				@(posedge clk);
			rgb_pending.push_back(want);
			pairs_sent++;
		end
		s_axis_tvalid <= 1'b0;

		while (rgb_pending.size() > 0)
			@(posedge clk);
		// a few more cycles to catch any stray transfer
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// receiver: runs of its own stall patterns, plus one long hold-off
	initial begin : stall_results
		int mode;
		int span;
		bit held;
		held = 1'b0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (!held && pairs_sent >= HOLD_AFTER) begin
				held = 1'b1;
				// the unit fills both stages and must push back on the input
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(5, 60);
			for (int phase = 0; phase < span; phase++) begin
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= (phase % 4) != 3;
					2: m_axis_tready <= 1'($urandom_range(0, 1));
					default: m_axis_tready <= (phase % 8) == 0;
				endcase
				@(posedge clk);
			end
		end
	end

	// each output transfer against the oldest pending result
	always @(posedge clk) begin : check_results
		yuvskip_pkg::out_item_t got;
		yuvskip_pkg::out_item_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = unpack_rgb(m_axis_tdata);
			if (rgb_pending.size() == 0) begin
				report_mismatch("transfer with no pending result, red_even", got.pix_even.red,
					0);
			end else begin
				want = rgb_pending.pop_front();
				check_field("red_even", got.pix_even.red, want.pix_even.red);
				check_field("green_even", got.pix_even.green, want.pix_even.green);
				check_field("blue_even", got.pix_even.blue, want.pix_even.blue);
				check_field("write_even", got.write_even, want.write_even);
				check_field("red_odd", got.pix_odd.red, want.pix_odd.red);
				check_field("green_odd", got.pix_odd.green, want.pix_odd.green);
				check_field("blue_odd", got.pix_odd.blue, want.pix_odd.blue);
				check_field("write_odd", got.write_odd, want.write_odd);
			end
			results_seen++;
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results pending", cycle_count,
			rgb_pending.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule
